// ===== design/quad_equal_power_panner_top_defines.svh =====
// assertion helpers for the quad panner
`ifndef QUAD_EQUAL_POWER_PANNER_TOP_DEFINES_SVH
`define QUAD_EQUAL_POWER_PANNER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QEPP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qepp check failed");

// next-cycle implication, checked out of reset
`define QEPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qepp check failed");

`endif

// ===== design/qepp_pkg.sv =====
package qepp_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int POS_BITS    = FRAC_BITS + 2;
	localparam int GAIN_BITS   = FRAC_BITS + 1;
	localparam int RAD_BITS    = 2 * GAIN_BITS;
	localparam int REM_BITS    = FRAC_BITS + 2;
	localparam int NUM_CELLS   = GAIN_BITS;
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int NUM_SPK     = 4;

	// speaker lanes
	localparam int SPK_FL = 0;
	localparam int SPK_BL = 1;
	localparam int SPK_FR = 2;
	localparam int SPK_BR = 3;

	localparam logic [GAIN_BITS-1:0] ONE_Q = GAIN_BITS'(1) << FRAC_BITS;

	// one square root in flight: radicand bits still to bring down, remainder, partial root
	typedef struct packed {
		logic [RAD_BITS-1:0]  rad;
		logic [REM_BITS-1:0]  rem;
		logic [GAIN_BITS-1:0] root;
	} sqrt_lane_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		sqrt_lane_t [NUM_SPK-1:0]      lane;
	} cell_data_t;

	typedef logic [NUM_SPK-1:0][SAMPLE_BITS-1:0] spk_vec_t;

endpackage

// ===== design/qepp_front.sv =====
module qepp_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic signed [qepp_pkg::SAMPLE_BITS-1:0] sample,
	input  logic signed [qepp_pkg::POS_BITS-1:0]    pos_x,
	input  logic signed [qepp_pkg::POS_BITS-1:0]    pos_y,
	output logic                                    out_valid,
	output qepp_pkg::cell_data_t                    out_data
);
	import qepp_pkg::*;

	// limit a position to 0..one
	function automatic logic [GAIN_BITS-1:0] clamp_pos(input logic signed [POS_BITS-1:0] p);
		if (p[POS_BITS-1]) begin
			return '0;
		end else if (p[POS_BITS-2:0] > ONE_Q) begin
			return ONE_Q;
		end else begin
			return p[GAIN_BITS-1:0];
		end
	endfunction

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [GAIN_BITS-1:0]          xr_s1, yr_s1, xl_s1, yb_s1;
	logic                          valid_s2;
	cell_data_t                    data_s2;
	logic [GAIN_BITS-1:0]          xr, yr;

	assign xr = clamp_pos(pos_x);
	assign yr = clamp_pos(pos_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= sample;
		xr_s1     <= xr;
		yr_s1     <= yr;
		xl_s1     <= ONE_Q - xr;
		yb_s1     <= ONE_Q - yr;
	end

	always_ff @(posedge clk) begin
		data_s2.sample            <= sample_s1;
		data_s2.lane[SPK_FL].rad  <= RAD_BITS'(xl_s1) * RAD_BITS'(yr_s1);
		data_s2.lane[SPK_BL].rad  <= RAD_BITS'(xl_s1) * RAD_BITS'(yb_s1);
		data_s2.lane[SPK_FR].rad  <= RAD_BITS'(xr_s1) * RAD_BITS'(yr_s1);
		data_s2.lane[SPK_BR].rad  <= RAD_BITS'(xr_s1) * RAD_BITS'(yb_s1);
		for (int l = 0; l < NUM_SPK; l++) begin
			data_s2.lane[l].rem  <= '0;
			data_s2.lane[l].root <= '0;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== design/qepp_sqrt_cell.sv =====
module qepp_sqrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  qepp_pkg::cell_data_t in_data,
	output logic                 out_valid,
	output qepp_pkg::cell_data_t out_data
);
	import qepp_pkg::*;

	logic       valid_s1;
	cell_data_t data_s1;
	cell_data_t next_data;

	// one root bit per lane: bring down two radicand bits, try (root << 2) | 1
	always_comb begin
		logic [REM_BITS+1:0] rem_ext;
		logic [REM_BITS+1:0] trial;
		next_data.sample = in_data.sample;
		for (int l = 0; l < NUM_SPK; l++) begin
			rem_ext = {in_data.lane[l].rem, in_data.lane[l].rad[RAD_BITS-1 -: 2]};
			trial   = (REM_BITS+2)'({in_data.lane[l].root, 2'b01});
			next_data.lane[l].rad = {in_data.lane[l].rad[RAD_BITS-3:0], 2'b00};
			if (rem_ext >= trial) begin
				next_data.lane[l].rem  = REM_BITS'(rem_ext - trial);
				next_data.lane[l].root = {in_data.lane[l].root[GAIN_BITS-2:0], 1'b1};
			end else begin
				next_data.lane[l].rem  = REM_BITS'(rem_ext);
				next_data.lane[l].root = {in_data.lane[l].root[GAIN_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= next_data;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== design/qepp_gain.sv =====
module qepp_gain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  qepp_pkg::cell_data_t in_data,
	output logic                 out_valid,
	output qepp_pkg::spk_vec_t   result
);
	import qepp_pkg::*;

	logic                        valid_s1, valid_s2;
	logic signed [PROD_BITS-1:0] prod_s1 [NUM_SPK];
	spk_vec_t                    result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_SPK; l++) begin
			prod_s1[l] <= PROD_BITS'(in_data.sample * $signed({1'b0, in_data.lane[l].root}));
		end
	end

	// arithmetic shift right, floor rounding, keep the low sample bits
	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_SPK; l++) begin
			result_s2[l] <= prod_s1[l][FRAC_BITS +: SAMPLE_BITS];
		end
	end

	assign out_valid = valid_s2;
	assign result    = result_s2;

endmodule

// ===== design/quad_equal_power_panner_top.sv =====
// equal-power quad panner
//
// command channel: an item (sample_in, pos_x, pos_y) is taken at a rising edge
// with start high and busy low. busy is always low, so an item can be taken
// in every cycle and the block runs at one item per cycle.
// pos_x and pos_y are signed q2.16 and are clamped to 0..1.0 on entry.
//
// result channel: done is high for exactly one cycle with the four speaker
// outputs on out_front_left, out_back_left, out_front_right, out_back_right.
// the receiver cannot stall; results leave in the order items came in.
//
// pipeline: an accepted item passes one clamp stage, one stage of four 17x17
// products, 17 square root cells (one root bit each), one stage of four
// sample-by-gain multipliers and one output register, and done is driven by
// the last of these. the square root chain makes up most of the pipeline.
//
// reset: arst_n clears all valid flags at once; items in flight are dropped.
// the data registers are not reset.

`include "quad_equal_power_panner_top_defines.svh"

module quad_equal_power_panner_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [qepp_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic signed [qepp_pkg::POS_BITS-1:0]    pos_x,
	input  logic signed [qepp_pkg::POS_BITS-1:0]    pos_y,
	output logic                                    done,
	output logic signed [qepp_pkg::SAMPLE_BITS-1:0] out_front_left,
	output logic signed [qepp_pkg::SAMPLE_BITS-1:0] out_back_left,
	output logic signed [qepp_pkg::SAMPLE_BITS-1:0] out_front_right,
	output logic signed [qepp_pkg::SAMPLE_BITS-1:0] out_back_right
);
	import qepp_pkg::*;

	// valid flags and data along the chain; index 0 is the chain input
	logic [NUM_CELLS:0] cell_valid;
	cell_data_t         cell_data [NUM_CELLS+1];
	spk_vec_t           result;

	// fully pipelined, never refuses an item
	assign busy = 1'b0;

	// clamp and form the four radicands
	qepp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.sample    (sample_in),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.out_valid (cell_valid[0]),
		.out_data  (cell_data[0])
	);

	// square root chain, one root bit per cell, msb first
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		qepp_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[i]),
			.in_data   (cell_data[i]),
			.out_valid (cell_valid[i+1]),
			.out_data  (cell_data[i+1])
		);
	end

	// scale the sample by each gain
	qepp_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cell_valid[NUM_CELLS]),
		.in_data   (cell_data[NUM_CELLS]),
		.out_valid (done),
		.result    (result)
	);

	assign out_front_left  = $signed(result[SPK_FL]);
	assign out_back_left   = $signed(result[SPK_BL]);
	assign out_front_right = $signed(result[SPK_FR]);
	assign out_back_right  = $signed(result[SPK_BR]);

	// an accepted item reaches the head of the chain through the clamp and product registers
	`QEPP_ASSERT_NEXT(a_chain_entry, start, ##1 cell_valid[0])

	// every result comes from an item that left the chain and passed the multiplier and output registers
	`QEPP_ASSERT_NOW(a_done_source, done, $past(cell_valid[NUM_CELLS], 2))

	// no gain can exceed full scale
	`QEPP_ASSERT_NOW(a_gain_range, cell_valid[NUM_CELLS],
		cell_data[NUM_CELLS].lane[SPK_FL].root <= ONE_Q &&
		cell_data[NUM_CELLS].lane[SPK_BL].root <= ONE_Q &&
		cell_data[NUM_CELLS].lane[SPK_FR].root <= ONE_Q &&
		cell_data[NUM_CELLS].lane[SPK_BR].root <= ONE_Q)

endmodule
